/* sv/mirror_set_read_balancer_unit_defines.svh */
// ----------------------------------------------------------------------------
// Mirror set read balancer: assertion macros
// Shared property wrappers, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef MIRROR_SET_READ_BALANCER_UNIT_DEFINES_SVH
`define MIRROR_SET_READ_BALANCER_UNIT_DEFINES_SVH

// Same-cycle implication
`define MRB_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mirror balancer check failed");

// Next-cycle implication
`define MRB_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mirror balancer check failed");

`endif

/* sv/mrb_pkg.sv */
// ----------------------------------------------------------------------------
// Mirror set read balancer package
// Request and status codes, sizes, sequencer states and shared types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mrb_pkg;
	localparam int MAX_MIRRORS = 8;
	localparam logic [16:0] RUN_MAX = 17'h1FFFF;

	typedef enum logic [2:0] {
		REQ_START  = 3'd0,
		REQ_READ   = 3'd1,
		REQ_WRITE  = 3'd2,
		REQ_RETRY  = 3'd3,
		REQ_FAIL   = 3'd4,
		REQ_SPARE  = 3'd5
	} req_t;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_NO_MIRROR = 3'd1;
	localparam logic [2:0] ST_LAST_DISK = 3'd2;
	localparam logic [2:0] ST_NOT_SPARE = 3'd3;
	localparam logic [2:0] ST_NO_READER = 3'd4;

	localparam logic [1:0] SP_WRITE_ONLY = 2'd0;
	localparam logic [1:0] SP_INACTIVE   = 2'd1;
	localparam logic [1:0] SP_ACTIVE     = 2'd2;

	localparam logic [1:0] CFG_MIRROR_COUNT = 2'd0;
	localparam logic [1:0] CFG_SECTOR_LIMIT = 2'd1;
	localparam logic [1:0] CFG_INIT_MASK    = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SEQ,
		S_SKIP,
		S_RING,
		S_FAIL,
		S_SPARE,
		S_FIN
	} state_t;

	typedef struct packed {
		logic        switch_mirror;
		logic [16:0] run_count;
		logic [31:0] next_expected;
	} run_res_t;
endpackage

/* sv/mrb_run_unit.sv */
// ----------------------------------------------------------------------------
// Mirror set read balancer: sequential run unit
// Registers the start sector of a read and judges the sequential run.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mrb_run_unit
	import mrb_pkg::*;
(
	input  logic        clk,
	input  logic        load,
	input  logic [31:0] block_number,
	input  logic [7:0]  block_sectors,
	input  logic [31:0] expected_sector,
	input  logic [16:0] run_count,
	input  logic [15:0] limit,
	output run_res_t    res
);
	logic [31:0] prod_q;
	logic [7:0]  sec_q;
	logic [17:0] sum;
	logic [16:0] sat;

	// 32x8 product, registered before use
	always_ff @(posedge clk) begin
		if (load) begin
			prod_q <= block_number * {24'd0, block_sectors};
			sec_q  <= block_sectors;
		end
	end

	always_comb begin
		sum = {1'b0, run_count} + {10'd0, sec_q};
		sat = sum[17] ? RUN_MAX : sum[16:0];
		res.run_count = sat;
		res.next_expected = prod_q + {24'd0, sec_q};
		if (prod_q == expected_sector) begin
			res.switch_mirror = (sat >= {1'b0, limit});
		end else begin
			res.switch_mirror = 1'b1;
		end
	end
endmodule

/* sv/mirror_set_read_balancer_unit.sv */
// ----------------------------------------------------------------------------
// Mirror set read balancer
// Chooses mirrors of a RAID-1 set for reads, writes, retries and upkeep.
// ----------------------------------------------------------------------------
// Requests arrive on the s_ stream, one transaction per request; one result
// transaction per request leaves on the m_ stream. Registers are to be written
// on the plain cfg_ port only while the block is idle; the user must keep to
// this; the block does not enforce it. A request is latched and executed;
// then write, retry, plain failure or spare change go straight to the result
// register; read judges the run and, on a switch, walks the ring past
// write-only members; start links the ring one slot per step, top down;
// failure relink and spare activation walk the slots one per step, then
// end the walk.
// The ring walks use one slot-stepping datapath driven by the sequencer;
// the read run arithmetic uses one registered 32x8 multiplier.
// s_tready is high only while the sequencer is idle. A finished result sits
// in the output register; the next request is taken while it waits, and a
// stalled receiver holds a later request at its final step.
// Reset clears every mark, the ring, the run state and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "mirror_set_read_balancer_unit_defines.svh"

module mirror_set_read_balancer_unit
	import mrb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	// req_type[2:0], block_number[34:3], block_sectors[42:35],
	// mirror_index[45:43], spare_state[47:46]
	input  logic [47:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// chosen_mirror[2:0], target_mask[10:3], target_count[14:11],
	// status[17:15], working_count[21:18]
	output logic [23:0] m_tdata
);
	// configuration
	logic [3:0]  mcount_q;
	logic [15:0] limit_q;
	logic [7:0]  imask_q;

	// set state
	logic [7:0]  op_q, wo_q, sp_q;
	logic [2:0]  nxt_q [MAX_MIRRORS];
	logic [2:0]  cur_q;
	logic [31:0] exp_q;
	logic [16:0] run_q;
	logic [3:0]  work_q;

	// request and sequencer
	state_t      state_q, state_d;
	logic [2:0]  req_q, idx_q, j_q, tgt_q;
	logic [1:0]  sps_q;
	logic [3:0]  k_q;
	logic [2:0]  chosen_q, stat_q;
	logic [7:0]  mask_q;
	logic [3:0]  cnt_q;

	// result register
	logic        mv_q;
	logic [21:0] mdat_q;

	logic        acc, out_load;
	logic [3:0]  n;
	logic [7:0]  in_slots, on_mask, op_slots;
	logic [2:0]  first_on, first_op;
	logic        any_op;
	logic [2:0]  ki;
	logic        fail_go, spare_go, skip_more, walk_end, spare_hit;
	run_res_t    rr;

	assign acc = s_tvalid && s_tready;

	mrb_run_unit u_run (
		.clk             (clk),
		.load            (acc),
		.block_number    (s_tdata[34:3]),
		.block_sectors   (s_tdata[42:35]),
		.expected_sector (exp_q),
		.run_count       (run_q),
		.limit           (limit_q),
		.res             (rr)
	);

	// Slot count and the masks derived from it
	always_comb begin
		if (mcount_q == 4'd0) n = 4'd1;
		else if (mcount_q > 4'(MAX_MIRRORS)) n = 4'(MAX_MIRRORS);
		else n = mcount_q;
		for (int i = 0; i < MAX_MIRRORS; i++) in_slots[i] = (4'(i) < n);
		on_mask  = imask_q & in_slots;
		op_slots = op_q & in_slots;
		first_on = '0;
		for (int i = MAX_MIRRORS - 1; i >= 0; i--) if (on_mask[i]) first_on = 3'(i);
		first_op = '0;
		any_op   = |op_slots;
		for (int i = MAX_MIRRORS - 1; i >= 0; i--) if (op_slots[i]) first_op = 3'(i);
	end

	// Sequencer conditions
	always_comb begin
		ki        = k_q[2:0];
		fail_go   = (work_q != 4'd1) && in_slots[idx_q] && op_q[idx_q];
		spare_go  = sp_q[idx_q] && (sps_q == SP_ACTIVE);
		skip_more = (k_q < 4'(MAX_MIRRORS)) && wo_q[cur_q];
		walk_end  = (k_q >= n);
		spare_hit = (ki != idx_q) && op_q[ki] && !wo_q[ki];
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (acc) state_d = S_EXEC;
			S_EXEC: begin
				case (req_q)
					REQ_START: state_d = (|on_mask) ? S_RING : S_FIN;
					REQ_READ:  state_d = S_SEQ;
					REQ_FAIL:  state_d = fail_go ? S_FAIL : S_FIN;
					REQ_SPARE: state_d = spare_go ? S_SPARE : S_FIN;
					default:   state_d = S_FIN;
				endcase
			end
			S_SEQ:   state_d = rr.switch_mirror ? S_SKIP : S_FIN;
			S_SKIP:  if (!skip_more) state_d = S_FIN;
			S_RING:  if (k_q == 4'd0) state_d = S_FIN;
			S_FAIL:  if (walk_end) state_d = S_FIN;
			S_SPARE: if (walk_end || spare_hit) state_d = S_FIN;
			S_FIN:   if (out_load) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Handshake outputs
	always_comb begin
		s_tready = (state_q == S_IDLE);
		out_load = (state_q == S_FIN) && (!mv_q || m_tready);
		m_tvalid = mv_q;
		m_tdata  = {2'b00, mdat_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mv_q    <= 1'b0;
			mdat_q  <= '0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				mv_q   <= 1'b1;
				mdat_q <= {work_q, stat_q, cnt_q, mask_q, chosen_q};
			end else if (m_tready) begin
				mv_q <= 1'b0;
			end
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mcount_q <= 4'd2;
			limit_q  <= 16'd128;
			imask_q  <= 8'd3;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MIRROR_COUNT: mcount_q <= cfg_wdata[3:0];
				CFG_SECTOR_LIMIT: limit_q  <= cfg_wdata;
				CFG_INIT_MASK:    imask_q  <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	// Set state and per-request datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q <= '0; wo_q <= '0; sp_q <= '0;
			for (int i = 0; i < MAX_MIRRORS; i++) nxt_q[i] <= '0;
			cur_q <= '0; exp_q <= '0; run_q <= '0; work_q <= '0;
			req_q <= '0; idx_q <= '0; sps_q <= '0; j_q <= '0; tgt_q <= '0;
			k_q <= '0; chosen_q <= '0; stat_q <= '0; mask_q <= '0; cnt_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: if (acc) begin
					// latch the request, clear the result fields
					req_q    <= s_tdata[2:0];
					idx_q    <= s_tdata[45:43];
					sps_q    <= s_tdata[47:46];
					k_q      <= '0;
					chosen_q <= '0;
					stat_q   <= ST_OK;
					mask_q   <= '0;
					cnt_q    <= '0;
				end
				S_EXEC: begin
					case (req_q)
						REQ_START: begin
							op_q   <= on_mask;
							wo_q   <= '0;
							sp_q   <= in_slots & ~on_mask;
							for (int i = 0; i < MAX_MIRRORS; i++) nxt_q[i] <= '0;
							exp_q  <= '0;
							run_q  <= '0;
							work_q <= 4'($countones(on_mask));
							cur_q  <= first_on;
							j_q    <= first_on;
							k_q    <= 4'(MAX_MIRRORS - 1);
							if (!(|on_mask)) stat_q <= ST_NO_MIRROR;
						end
						REQ_READ: chosen_q <= cur_q;
						REQ_WRITE: begin
							mask_q <= op_slots;
							cnt_q  <= 4'($countones(op_slots));
						end
						REQ_RETRY: begin
							chosen_q <= first_op;
							stat_q   <= (!any_op || first_op == idx_q) ? ST_NO_MIRROR : ST_OK;
						end
						REQ_FAIL: begin
							if (work_q == 4'd1) begin
								stat_q <= (in_slots[idx_q] && !op_q[idx_q]) ? ST_OK : ST_LAST_DISK;
							end else if (fail_go) begin
								op_q[idx_q] <= 1'b0;
								tgt_q       <= nxt_q[idx_q];
								if (work_q != 4'd0) work_q <= work_q - 4'd1;
							end
						end
						REQ_SPARE: begin
							if (!sp_q[idx_q]) begin
								stat_q <= ST_NOT_SPARE;
							end else begin
								case (sps_q)
									SP_WRITE_ONLY: begin
										op_q[idx_q] <= 1'b1;
										wo_q[idx_q] <= 1'b1;
									end
									SP_INACTIVE: begin
										op_q[idx_q] <= 1'b0;
										wo_q[idx_q] <= 1'b0;
									end
									SP_ACTIVE: begin
										sp_q[idx_q] <= 1'b0;
										wo_q[idx_q] <= 1'b0;
										if (work_q < 4'(MAX_MIRRORS)) work_q <= work_q + 4'd1;
									end
									default: stat_q <= ST_NO_MIRROR;
								endcase
							end
						end
						default: ;
					endcase
				end
				S_SEQ: begin
					exp_q <= rr.next_expected;
					if (rr.switch_mirror) begin
						run_q <= '0;
						cur_q <= nxt_q[cur_q];
						k_q   <= '0;
					end else begin
						run_q <= rr.run_count;
					end
				end
				S_SKIP: begin
					// advance past write-only members, bounded by MAX_MIRRORS
					if (skip_more) begin
						cur_q <= nxt_q[cur_q];
						k_q   <= k_q + 4'd1;
					end else if (wo_q[cur_q]) begin
						stat_q <= ST_NO_READER;
					end
				end
				S_RING: begin
					// link operational slots top down, wrapping to the lowest
					if (op_q[ki]) begin
						nxt_q[ki] <= j_q;
						j_q       <= ki;
					end
					if (k_q != 4'd0) k_q <= k_q - 4'd1;
				end
				S_FAIL: if (!walk_end) begin
					if (nxt_q[ki] == idx_q) nxt_q[ki] <= tgt_q;
					k_q <= k_q + 4'd1;
				end
				S_SPARE: begin
					if (walk_end) begin
						stat_q <= ST_NO_READER;
					end else if (spare_hit) begin
						nxt_q[ki]    <= idx_q;
						nxt_q[idx_q] <= nxt_q[ki];
					end else begin
						k_q <= k_q + 4'd1;
					end
				end
				default: ;
			endcase
		end
	end

	`MRB_ASSERT_NEXT(a_one_at_a_time, acc, !s_tready)
	`MRB_ASSERT_NOW(a_skip_bounded, state_q == S_SKIP, k_q <= 4'(MAX_MIRRORS))
	`MRB_ASSERT_NOW(a_work_bounded, m_tvalid, m_tdata[21:18] <= 4'(MAX_MIRRORS))
endmodule

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// Mirror set read balancer testbench
// Drives requests in bursts against a stalling receiver and checks every
// result against a cycle-free prediction of mirror choice and ring upkeep.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
	import mrb_pkg::*;

	typedef struct packed {
		logic [1:0]  spare_state;
		logic [2:0]  mirror_index;
		logic [7:0]  block_sectors;
		logic [31:0] block_number;
		logic [2:0]  req_type;
	} request_t;

	typedef struct packed {
		logic [1:0] pad;
		logic [3:0] working_count;
		logic [2:0] status;
		logic [3:0] target_count;
		logic [7:0] target_mask;
		logic [2:0] chosen_mirror;
	} outcome_t;

	// directed row: request plus an optional typed-in outcome
	typedef struct {
		request_t req;
		bit       fixed;
		outcome_t want;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_wdata = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;

	// predictor state
	logic [3:0]  cnt_reg;
	logic [15:0] limit_reg;
	logic [7:0]  mask_reg;
	bit          op_mark [MAX_MIRRORS];
	bit          wo_mark [MAX_MIRRORS];
	bit          sp_mark [MAX_MIRRORS];
	logic [2:0]  link [MAX_MIRRORS];
	logic [2:0]  cur_mirror;
	logic [31:0] next_sector;
	logic [16:0] run_len;
	logic [3:0]  working;

	outcome_t pending_outcomes[$];
	int       mismatches = 0;
	int       results_seen = 0;
	int       cycles = 0;
	int       long_hold = 0;
	bit       end_run = 0;

	mirror_set_read_balancer_unit dut (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic int slot_count();
		if (cnt_reg == 0) return 1;
		if (cnt_reg > MAX_MIRRORS) return MAX_MIRRORS;
		return cnt_reg;
	endfunction

	// Work out the outcome of one request and advance the mirror state.
	function automatic outcome_t balance_request(request_t r);
		outcome_t o;
		int n, first, i, k;
		logic [2:0] j, c, after;
		logic [31:0] prod;
		logic [17:0] sum;
		bit sw;
		o = '0;
		n = slot_count();
		case (r.req_type)
		REQ_START: begin
			working = 0;
			first = -1;
			for (i = 0; i < MAX_MIRRORS; i++) begin
				op_mark[i] = (i < n) && mask_reg[i];
				wo_mark[i] = 0;
				sp_mark[i] = (i < n) && !op_mark[i];
				link[i] = 0;
				if (op_mark[i]) begin
					working++;
					if (first < 0) first = i;
				end
			end
			next_sector = 0;
			run_len = 0;
			if (first < 0) begin
				cur_mirror = 0;
				o.status = ST_NO_MIRROR;
			end else begin
				cur_mirror = 3'(first);
				j = 3'(first);
				for (i = n - 1; i >= 0; i--)
					if (op_mark[i]) begin
						link[i] = j;
						j = 3'(i);
					end
			end
		end
		REQ_READ: begin
			c = cur_mirror;
			o.chosen_mirror = c;
			prod = r.block_number * {24'd0, r.block_sectors};
			sw = 1;
			if (prod == next_sector) begin
				sum = run_len + r.block_sectors;
				run_len = (sum > RUN_MAX) ? RUN_MAX : sum[16:0];
				sw = run_len >= limit_reg;
			end
			next_sector = (r.block_number + 1) * {24'd0, r.block_sectors};
			if (sw) begin
				run_len = 0;
				c = link[c];
				for (k = 0; k < MAX_MIRRORS && wo_mark[c]; k++) c = link[c];
				if (wo_mark[c]) o.status = ST_NO_READER;
				cur_mirror = c;
			end
		end
		REQ_WRITE: begin
			for (i = 0; i < n; i++)
				if (op_mark[i]) begin
					o.target_mask[i] = 1'b1;
					o.target_count++;
				end
		end
		REQ_RETRY: begin
			o.status = ST_NO_MIRROR;
			for (i = 0; i < n; i++)
				if (op_mark[i]) begin
					o.chosen_mirror = 3'(i);
					o.status = (i == r.mirror_index) ? ST_NO_MIRROR : ST_OK;
					break;
				end
		end
		REQ_FAIL: begin
			if (working == 1) begin
				if (!(r.mirror_index < n && !op_mark[r.mirror_index]))
					o.status = ST_LAST_DISK;
			end else if (r.mirror_index < n && op_mark[r.mirror_index]) begin
				op_mark[r.mirror_index] = 0;
				after = link[r.mirror_index];
				for (i = 0; i < n; i++)
					if (link[i] == r.mirror_index) link[i] = after;
				if (working > 0) working--;
			end
		end
		REQ_SPARE: begin
			if (!sp_mark[r.mirror_index]) o.status = ST_NOT_SPARE;
			else if (r.spare_state == SP_WRITE_ONLY) begin
				op_mark[r.mirror_index] = 1;
				wo_mark[r.mirror_index] = 1;
			end else if (r.spare_state == SP_INACTIVE) begin
				op_mark[r.mirror_index] = 0;
				wo_mark[r.mirror_index] = 0;
			end else if (r.spare_state == SP_ACTIVE) begin
				sp_mark[r.mirror_index] = 0;
				wo_mark[r.mirror_index] = 0;
				if (working < MAX_MIRRORS) working++;
				o.status = ST_NO_READER;
				for (i = 0; i < n; i++)
					if (i != r.mirror_index && op_mark[i] && !wo_mark[i]) begin
						after = link[i];
						link[i] = r.mirror_index;
						link[r.mirror_index] = after;
						o.status = ST_OK;
						break;
					end
			end else o.status = ST_NO_MIRROR;
		end
		default: ;
		endcase
		o.working_count = working;
		return o;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("[%0t] %s: got %0d, expected %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	// Result checker: compare each accepted transaction with the oldest expectation.
	always @(posedge clk) begin
		outcome_t got, want;
		if (m_tvalid && m_tready) begin
			got = outcome_t'(m_tdata);
			results_seen++;
			if (pending_outcomes.size() == 0)
				report_mismatch("unexpected result", results_seen, 0);
			else begin
				want = pending_outcomes.pop_front();
				if (got.chosen_mirror !== want.chosen_mirror)
					report_mismatch("chosen_mirror", got.chosen_mirror, want.chosen_mirror);
				if (got.target_mask !== want.target_mask)
					report_mismatch("target_mask", got.target_mask, want.target_mask);
				if (got.target_count !== want.target_count)
					report_mismatch("target_count", got.target_count, want.target_count);
				if (got.status !== want.status)
					report_mismatch("status", got.status, want.status);
				if (got.working_count !== want.working_count)
					report_mismatch("working_count", got.working_count, want.working_count);
			end
		end
	end

	// Receiver: own stall pattern; a long hold-off counted here on request.
	always @(posedge clk) begin
		if (long_hold > 0) begin
			m_tready <= 1'b0;
			long_hold <= long_hold - 1;
		end else if (cycles % 97 < 40) m_tready <= 1'b1;
		else m_tready <= ($urandom_range(0, 3) != 0);
	end

	// Write one register; the enable drops on the following edge.
	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
		CFG_MIRROR_COUNT: cnt_reg = val[3:0];
		CFG_SECTOR_LIMIT: limit_reg = val;
		default: mask_reg = val[7:0];
		endcase
		@(posedge clk);
	endtask

	// Hold until every expected result is in, then let the block settle.
	task automatic drain();
		while (pending_outcomes.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// Offer one request and hold it until accepted; the outcome is queued at acceptance.
	task automatic send_request(request_t r, bit fixed, outcome_t want);
		outcome_t o;
		s_tvalid <= 1'b1;
		s_tdata <= r;
		do @(posedge clk); while (!s_tready);
		o = balance_request(r);
		if (fixed && o != want) report_mismatch("table row vs prediction", o, want);
		pending_outcomes.push_back(o);
	endtask

	function automatic request_t random_request();
		request_t r;
		int pick;
		r.block_number = $urandom();
		r.block_sectors = 8'($urandom_range(1, 255));
		r.mirror_index = 3'($urandom_range(0, 7));
		r.spare_state = 2'($urandom_range(0, 3));
		pick = $urandom_range(0, 99);
		if (pick < 50) begin
			r.req_type = REQ_READ;
			// mostly sequential runs so the sector count reaches the limit
			if (pick < 40 && next_sector % 8 == 0) begin
				r.block_sectors = 8;
				r.block_number = next_sector / 8;
			end
		end else if (pick < 60) r.req_type = REQ_WRITE;
		else if (pick < 68) r.req_type = REQ_RETRY;
		else if (pick < 78) r.req_type = REQ_FAIL;
		else if (pick < 93) r.req_type = REQ_SPARE;
		else if (pick < 97) r.req_type = REQ_START;
		else r.req_type = 3'($urandom_range(6, 7));
		return r;
	endfunction

	function automatic row_t row(logic [2:0] t, logic [31:0] b, logic [7:0] s,
			logic [2:0] m, logic [1:0] sp, bit fixed = 0, outcome_t want = '0);
		row_t x;
		x.req = '{spare_state: sp, mirror_index: m, block_sectors: s,
			block_number: b, req_type: t};
		x.fixed = fixed;
		x.want = want;
		return x;
	endfunction

	initial begin
		row_t directed[$];
		int i, p;
		logic [15:0] limits [4];
		limits = '{16'd1, 16'd16, 16'd128, 16'hFFFF};
		cnt_reg = 2;
		limit_reg = 128;
		mask_reg = 3;
		for (i = 0; i < MAX_MIRRORS; i++) begin
			op_mark[i] = 0; wo_mark[i] = 0; sp_mark[i] = 0; link[i] = 0;
		end
		cur_mirror = 0; next_sector = 0; run_len = 0; working = 0;

		// Stimulus table: after-reset, extremes, every request kind, error codes.
		directed.push_back(row(REQ_WRITE, 0, 1, 0, 0, 1, '0));
		directed.push_back(row(REQ_READ, 0, 1, 0, 0, 1, '0));
		directed.push_back(row(REQ_RETRY, 0, 1, 0, 0, 1,
			'{0, 0, ST_NO_MIRROR, 0, 0, 0}));
		directed.push_back(row(REQ_START, 0, 1, 0, 0, 1, '{0, 2, ST_OK, 0, 0, 0}));
		directed.push_back(row(REQ_WRITE, 0, 1, 0, 0, 1, '{0, 2, ST_OK, 2, 3, 0}));
		directed.push_back(row(REQ_READ, 0, 255, 0, 0));
		directed.push_back(row(REQ_READ, 1, 255, 0, 0));
		directed.push_back(row(REQ_READ, 32'hFFFFFFFF, 255, 0, 0));
		directed.push_back(row(REQ_READ, 32'hFFFFFFFF, 1, 7, 3));
		directed.push_back(row(REQ_RETRY, 0, 1, 0, 0, 1,
			'{0, 2, ST_NO_MIRROR, 0, 0, 0}));
		directed.push_back(row(REQ_RETRY, 0, 1, 5, 0, 1, '{0, 2, ST_OK, 0, 0, 0}));
		directed.push_back(row(REQ_SPARE, 0, 1, 7, 2, 1,
			'{0, 2, ST_NOT_SPARE, 0, 0, 0}));
		directed.push_back(row(REQ_FAIL, 0, 1, 7, 0, 1, '{0, 2, ST_OK, 0, 0, 0}));
		directed.push_back(row(REQ_FAIL, 0, 1, 0, 0, 1, '{0, 1, ST_OK, 0, 0, 0}));
		directed.push_back(row(REQ_FAIL, 0, 1, 1, 0, 1,
			'{0, 1, ST_LAST_DISK, 0, 0, 0}));
		directed.push_back(row(REQ_FAIL, 0, 1, 0, 0, 1, '{0, 1, ST_OK, 0, 0, 0}));
		directed.push_back(row(3'd6, 0, 1, 0, 0, 1, '{0, 1, ST_OK, 0, 0, 0}));
		directed.push_back(row(3'd7, 0, 1, 0, 0, 1, '{0, 1, ST_OK, 0, 0, 0}));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[k]) send_request(directed[k].req, directed[k].fixed,
			directed[k].want);
		s_tvalid <= 1'b0;
		drain();

		// Eight-slot set with four spares: write-only resync, activation, skips.
		write_reg(CFG_MIRROR_COUNT, 8);
		write_reg(CFG_SECTOR_LIMIT, 1);
		write_reg(CFG_INIT_MASK, 16'h3C);
		send_request(row(REQ_START, 0, 1, 0, 0).req, 0, '0);
		send_request(row(REQ_SPARE, 0, 1, 0, SP_WRITE_ONLY).req, 0, '0);
		send_request(row(REQ_SPARE, 0, 1, 1, SP_ACTIVE).req, 0, '0);
		send_request(row(REQ_SPARE, 0, 1, 0, 3).req, 0, '0);
		send_request(row(REQ_SPARE, 0, 1, 6, SP_INACTIVE).req, 0, '0);
		for (i = 0; i < 6; i++) send_request(row(REQ_READ, i, 4, 0, 0).req, 0, '0);
		s_tvalid <= 1'b0;
		drain();

		// Random phases across register settings; bursts with gaps.
		for (p = 0; p < 8; p++) begin
			write_reg(CFG_MIRROR_COUNT,
				16'((p == 0) ? 0 : (p == 1) ? 15 : $urandom_range(1, 8)));
			write_reg(CFG_SECTOR_LIMIT, limits[p % 4]);
			write_reg(CFG_INIT_MASK,
				16'((p == 2) ? 0 : (p == 3) ? 255 : $urandom_range(0, 255)));
			send_request(row(REQ_START, 0, 1, 0, 0).req, 0, '0);
			if (p == 4) long_hold <= 300;
			i = 0;
			while (i < 60) begin
				int burst;
				burst = $urandom_range(1, 12);
				repeat (burst) begin
					send_request(random_request(), 0, '0);
					i++;
				end
				if ($urandom_range(0, 2) != 0) begin
					s_tvalid <= 1'b0;
					repeat ($urandom_range(1, 15)) @(posedge clk);
				end
			end
			s_tvalid <= 1'b0;
			drain();
		end

		$display("Covered %0d results over directed rows, spare upkeep and eight random phases",
			results_seen);
		if (mismatches == 0) $display("No mismatches found");
		else $display("Mismatches found");
		$finish;
	end
endmodule

/* filelist.f */
+incdir+sv
sv/mrb_pkg.sv
sv/mrb_run_unit.sv
sv/mirror_set_read_balancer_unit.sv
dv/tb_top.sv
